@@ design/j1939_bam_reassembler_macros.svh @@
// Assertion helpers for the reassembler.
`ifndef J1939_BAM_REASSEMBLER_MACROS_SVH
`define J1939_BAM_REASSEMBLER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JBAM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JBAM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/jbam_pkg.sv @@
package jbam_pkg;

    localparam logic [15:0] GRP_CM   = 16'hEC00;
    localparam logic [15:0] GRP_DT   = 16'hEB00;
    localparam logic [15:0] GRP_DM1  = 16'hFECA;
    localparam logic [23:0] GRP_IDLE = 24'h00FEE3;
    localparam logic [7:0]  BAM_CTRL = 8'h20;
    localparam logic [7:0]  PDU2_MIN = 8'hF0;
    localparam int          DT_BYTES = 7;
    localparam logic [3:0]  FULL_LEN = 4'd8;
    localparam logic [3:0]  DM1_MIN_LEN = 4'd2;
    localparam int          MAP_DEPTH = 256;
    // Byte offset (seq - 1) * 7 plus the in-packet index fits in 11 bits.
    localparam int          OFF_W = 11;

    localparam logic [1:0] KIND_BYTE  = 2'd0;
    localparam logic [1:0] KIND_EMPTY = 2'd1;
    localparam logic [1:0] KIND_DM1   = 2'd2;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_WRITE,
        S_RD0,
        S_RD1,
        S_RD2,
        S_EMIT,
        S_EMPTY,
        S_DM1
    } t_state;

endpackage

@@ design/jbam_ram.sv @@
module jbam_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

@@ design/j1939_bam_reassembler.sv @@
// Flow: BAM and ignored frames leave busy low; a TP.DT frame steps through 7 byte writes
// (single payload memory write port); a completing frame then passes through RD0, RD1 and
// RD2 and shows one result per cycle, size results in all, or one empty result for size 0.
// Throughput: busy stays high until the frame's last result has been shown.
// Reset: synchronous active low; afterwards a clearing pass over max(SESSIONS*PAYLOAD_CAP, 256)
// addresses zeroes the payload memory and DM1 source map while busy is high.
`include "j1939_bam_reassembler_macros.svh"

module j1939_bam_reassembler #(
    parameter int SESSIONS    = 4,
    parameter int PAYLOAD_CAP = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [28:0] i_can_id,
    input  logic [3:0]  i_frame_length,
    input  logic [7:0]  i_byte_0,
    input  logic [7:0]  i_byte_1,
    input  logic [7:0]  i_byte_2,
    input  logic [7:0]  i_byte_3,
    input  logic [7:0]  i_byte_4,
    input  logic [7:0]  i_byte_5,
    input  logic [7:0]  i_byte_6,
    input  logic [7:0]  i_byte_7,
    output logic        o_valid,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_source_address,
    output logic [23:0] o_group_number,
    output logic [6:0]  o_payload_size,
    output logic [5:0]  o_byte_index,
    output logic [7:0]  o_byte_value,
    output logic [12:0] o_idle_rpm,
    output logic        o_idle_rpm_valid,
    output logic [7:0]  o_lamp_status,
    output logic [7:0]  o_dm1_source_count,
    output logic        o_last
);

    localparam int SW        = (SESSIONS > 1) ? $clog2(SESSIONS) : 1;
    localparam int LW        = $clog2(PAYLOAD_CAP + 1);
    localparam int PAY_DEPTH = SESSIONS * PAYLOAD_CAP;
    localparam int PAW       = $clog2(PAY_DEPTH);
    localparam int MAW       = $clog2(jbam_pkg::MAP_DEPTH);
    localparam int CLR_DEPTH = (PAY_DEPTH > jbam_pkg::MAP_DEPTH) ? PAY_DEPTH
                                                                 : jbam_pkg::MAP_DEPTH;
    localparam int CLR_W     = $clog2(CLR_DEPTH + 1);
    localparam int OW        = jbam_pkg::OFF_W;

    jbam_pkg::t_state r_state, n_state;

    logic            r_busy     [SESSIONS];
    logic [7:0]      r_source   [SESSIONS];
    logic [23:0]     r_group    [SESSIONS];
    logic [LW-1:0]   r_len      [SESSIONS];
    logic [7:0]      r_pkts     [SESSIONS];
    logic [7:0]      r_rcvd     [SESSIONS];
    logic [7:0]      r_data     [jbam_pkg::DT_BYTES];

    logic [CLR_W-1:0] r_clr;
    logic [SW-1:0]    r_slot;
    logic [OW-1:0]    r_off;
    logic [2:0]       r_i;
    logic             r_done;
    logic [LW-1:0]    r_idx;
    logic [7:0]       r_b0, r_b1;
    logic [7:0]       r_dm1_src, r_lamp, r_cnt;

    // Frame decode on the input ports.
    logic [7:0]  src, pf, ps;
    logic [15:0] grp;
    logic        acc, is_cm, is_dt, is_dm1;
    assign src = i_can_id[7:0];
    assign ps  = i_can_id[15:8];
    assign pf  = i_can_id[23:16];
    assign grp = (pf < jbam_pkg::PDU2_MIN) ? {pf, 8'h00} : {pf, ps};
    assign acc = start && !busy;
    assign is_cm  = (grp == jbam_pkg::GRP_CM) && (i_frame_length == jbam_pkg::FULL_LEN)
                    && (i_byte_0 == jbam_pkg::BAM_CTRL);
    assign is_dt  = (grp == jbam_pkg::GRP_DT) && (i_frame_length == jbam_pkg::FULL_LEN);
    assign is_dm1 = (grp == jbam_pkg::GRP_DM1) && (i_frame_length >= jbam_pkg::DM1_MIN_LEN);

    // Slot lookup: matching busy slot first, else first free slot, else slot 0.
    logic          hit, free_found, lk_alloc;
    logic [SW-1:0] hit_idx, free_idx, lk;
    always_comb begin
        hit        = 1'b0;
        free_found = 1'b0;
        hit_idx    = '0;
        free_idx   = '0;
        for (int k = SESSIONS - 1; k >= 0; k--) begin
            if (r_busy[k] && r_source[k] == src) begin
                hit     = 1'b1;
                hit_idx = SW'(k);
            end
            if (!r_busy[k]) begin
                free_found = 1'b1;
                free_idx   = SW'(k);
            end
        end
    end
    assign lk       = hit ? hit_idx : (free_found ? free_idx : '0);
    assign lk_alloc = !hit && free_found;

    logic [7:0] lk_pkts, rcvd_inc;
    logic       dt_bad;
    assign lk_pkts  = r_pkts[lk];
    assign rcvd_inc = r_rcvd[lk] + 8'd1;
    assign dt_bad   = (lk_pkts == 8'd0) || (i_byte_0 == 8'd0) || (i_byte_0 > lk_pkts);

    logic [15:0] cm_size;
    logic [LW-1:0] cm_len;
    assign cm_size = {i_byte_2, i_byte_1};
    assign cm_len  = (cm_size > 16'(PAYLOAD_CAP)) ? LW'(PAYLOAD_CAP) : LW'(cm_size);

    logic [OW-1:0] seq_m1, wr_off;
    assign seq_m1 = OW'(i_byte_0 - 8'd1);
    assign wr_off = r_off + OW'(r_i);

    logic [LW-1:0]  cur_len;
    logic [PAW-1:0] base;
    assign cur_len = r_len[r_slot];
    assign base    = PAW'(r_slot) * PAW'(PAYLOAD_CAP);

    logic           pay_we, map_we, map_wdata, map_rdata;
    logic [PAW-1:0] pay_waddr, pay_raddr;
    logic [7:0]     pay_wdata, pay_rdata;
    logic [MAW-1:0] map_waddr, map_raddr;
    logic           emit_last;
    assign emit_last = (r_idx + LW'(1)) == cur_len;

    jbam_ram #(.WIDTH(8), .DEPTH(PAY_DEPTH)) u_payload (
        .i_clk   (i_clk),
        .i_we    (pay_we),
        .i_waddr (pay_waddr),
        .i_wdata (pay_wdata),
        .i_raddr (pay_raddr),
        .o_rdata (pay_rdata)
    );

    jbam_ram #(.WIDTH(1), .DEPTH(jbam_pkg::MAP_DEPTH)) u_dm1_map (
        .i_clk   (i_clk),
        .i_we    (map_we),
        .i_waddr (map_waddr),
        .i_wdata (map_wdata),
        .i_raddr (map_raddr),
        .o_rdata (map_rdata)
    );

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            jbam_pkg::S_CLEAR: begin
                if (r_clr == CLR_W'(CLR_DEPTH - 1)) n_state = jbam_pkg::S_IDLE;
            end
            jbam_pkg::S_IDLE: begin
                if (acc && is_dt && !is_cm && !dt_bad) n_state = jbam_pkg::S_WRITE;
                else if (acc && is_dm1 && !is_cm && !is_dt) n_state = jbam_pkg::S_DM1;
            end
            jbam_pkg::S_WRITE: begin
                if (r_i == 3'(jbam_pkg::DT_BYTES - 1)) begin
                    if (!r_done) n_state = jbam_pkg::S_IDLE;
                    else if (cur_len == '0) n_state = jbam_pkg::S_EMPTY;
                    else n_state = jbam_pkg::S_RD0;
                end
            end
            jbam_pkg::S_RD0: n_state = jbam_pkg::S_RD1;
            jbam_pkg::S_RD1: n_state = jbam_pkg::S_RD2;
            jbam_pkg::S_RD2: n_state = jbam_pkg::S_EMIT;
            jbam_pkg::S_EMIT: begin
                if (emit_last) n_state = jbam_pkg::S_IDLE;
            end
            jbam_pkg::S_EMPTY: n_state = jbam_pkg::S_IDLE;
            jbam_pkg::S_DM1: n_state = jbam_pkg::S_IDLE;
            default: n_state = jbam_pkg::S_IDLE;
        endcase
    end

    // Outputs and memory ports.
    always_comb begin
        busy               = (r_state != jbam_pkg::S_IDLE);
        o_valid            = 1'b0;
        o_kind             = jbam_pkg::KIND_BYTE;
        o_source_address   = '0;
        o_group_number     = '0;
        o_payload_size     = '0;
        o_byte_index       = '0;
        o_byte_value       = '0;
        o_idle_rpm         = '0;
        o_idle_rpm_valid   = 1'b0;
        o_lamp_status      = '0;
        o_dm1_source_count = '0;
        o_last             = 1'b0;
        pay_we             = 1'b0;
        pay_waddr          = base + PAW'(wr_off);
        pay_wdata          = r_data[r_i];
        pay_raddr          = base;
        map_we             = 1'b0;
        map_waddr          = r_dm1_src;
        map_wdata          = 1'b1;
        map_raddr          = src;
        unique case (r_state)
            jbam_pkg::S_CLEAR: begin
                pay_we    = r_clr < CLR_W'(PAY_DEPTH);
                pay_waddr = PAW'(r_clr);
                pay_wdata = '0;
                map_we    = r_clr < CLR_W'(jbam_pkg::MAP_DEPTH);
                map_waddr = MAW'(r_clr);
                map_wdata = 1'b0;
            end
            jbam_pkg::S_WRITE: begin
                pay_we = wr_off < OW'(cur_len);
            end
            jbam_pkg::S_RD1: begin
                pay_raddr = base + PAW'(1);
            end
            jbam_pkg::S_EMIT, jbam_pkg::S_EMPTY: begin
                pay_raddr        = base + PAW'(r_idx) + PAW'(1);
                o_valid          = 1'b1;
                o_kind           = (r_state == jbam_pkg::S_EMIT) ? jbam_pkg::KIND_BYTE
                                                                 : jbam_pkg::KIND_EMPTY;
                o_source_address = r_source[r_slot];
                o_group_number   = r_group[r_slot];
                o_payload_size   = 7'(cur_len);
                o_idle_rpm_valid = (r_group[r_slot] == jbam_pkg::GRP_IDLE)
                                   && (cur_len >= LW'(2));
                o_idle_rpm       = o_idle_rpm_valid ? 13'({r_b1, r_b0} >> 3) : '0;
                if (r_state == jbam_pkg::S_EMIT) begin
                    o_byte_index = 6'(r_idx);
                    o_byte_value = pay_rdata;
                    o_last       = emit_last;
                end else begin
                    o_last = 1'b1;
                end
            end
            jbam_pkg::S_DM1: begin
                if (!map_rdata) begin
                    map_we             = 1'b1;
                    o_valid            = 1'b1;
                    o_kind             = jbam_pkg::KIND_DM1;
                    o_source_address   = r_dm1_src;
                    o_lamp_status      = r_lamp;
                    o_dm1_source_count = r_cnt + 8'd1;
                    o_last             = 1'b1;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jbam_pkg::S_CLEAR;
            r_clr   <= '0;
            r_cnt   <= '0;
            r_i     <= '0;
            r_idx   <= '0;
            for (int k = 0; k < SESSIONS; k++) begin
                r_busy[k]   <= 1'b0;
                r_source[k] <= '0;
                r_group[k]  <= '0;
                r_len[k]    <= '0;
                r_pkts[k]   <= '0;
                r_rcvd[k]   <= '0;
            end
        end else begin
            r_state <= n_state;
            unique case (r_state)
                jbam_pkg::S_CLEAR: r_clr <= r_clr + CLR_W'(1);
                jbam_pkg::S_IDLE: begin
                    if (acc && (is_cm || is_dt) && lk_alloc) begin
                        r_busy[lk]   <= 1'b1;
                        r_source[lk] <= src;
                    end
                    if (acc && is_cm) begin
                        r_group[lk] <= {i_byte_7, i_byte_6, i_byte_5};
                        r_len[lk]   <= cm_len;
                        r_pkts[lk]  <= i_byte_3;
                        r_rcvd[lk]  <= '0;
                    end else if (acc && is_dt && !dt_bad) begin
                        r_rcvd[lk] <= rcvd_inc;
                        r_done     <= rcvd_inc == lk_pkts;
                        r_slot     <= lk;
                        r_off      <= (seq_m1 << 3) - seq_m1;
                        r_i        <= '0;
                        r_data[0]  <= i_byte_1;
                        r_data[1]  <= i_byte_2;
                        r_data[2]  <= i_byte_3;
                        r_data[3]  <= i_byte_4;
                        r_data[4]  <= i_byte_5;
                        r_data[5]  <= i_byte_6;
                        r_data[6]  <= i_byte_7;
                    end else if (acc && is_dm1) begin
                        r_dm1_src <= src;
                        r_lamp    <= i_byte_0;
                    end
                end
                jbam_pkg::S_WRITE: r_i <= r_i + 3'd1;
                jbam_pkg::S_RD1: r_b0 <= pay_rdata;
                jbam_pkg::S_RD2: begin
                    r_b1  <= pay_rdata;
                    r_idx <= '0;
                end
                jbam_pkg::S_EMIT: begin
                    r_idx <= r_idx + LW'(1);
                    if (emit_last) begin
                        r_busy[r_slot] <= 1'b0;
                        r_pkts[r_slot] <= '0;
                    end
                end
                jbam_pkg::S_EMPTY: begin
                    r_busy[r_slot] <= 1'b0;
                    r_pkts[r_slot] <= '0;
                end
                jbam_pkg::S_DM1: begin
                    if (!map_rdata) r_cnt <= r_cnt + 8'd1;
                end
                default: begin
                end
            endcase
        end
    end

    `JBAM_ASSERT_NOW(a_valid_busy, o_valid, busy, "result shown while not busy")
    `JBAM_ASSERT_NEXT(a_last_idle, o_valid && o_last, !o_valid && !busy, "run did not end")
    `JBAM_ASSERT_NEXT(a_index_step, o_valid && !o_last && o_kind == jbam_pkg::KIND_BYTE,
        o_valid && o_byte_index == $past(o_byte_index) + 6'd1, "byte index skipped")

endmodule
